// ===== design/fpr_pkg.sv =====
// ----------------------------------------------------------------------------
// fpr_pkg - shared types and constants of the framed packet receiver
// Parser phases, the result item record and the configuration register
// indexes used by the parser, the output buffer and the top level.
// ----------------------------------------------------------------------------
package fpr_pkg;

    // configuration port
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 2'd1;

    // reset values of the sync registers
    localparam logic [7:0] SYNC_FIRST_RST  = 8'd181;
    localparam logic [7:0] SYNC_SECOND_RST = 8'd98;

    // field widths
    localparam int unsigned BYTE_INDEX_W = 10;
    localparam int unsigned LENGTH_W     = 16;
    localparam int unsigned OUT_TDATA_W  = 56;

    // kind of a result item
    typedef enum logic {
        KIND_PAYLOAD   = 1'b0,
        KIND_FRAME_END = 1'b1
    } t_kind;

    // position within a frame
    typedef enum logic [3:0] {
        PH_HUNT,
        PH_SYNC2,
        PH_CLASS,
        PH_ID,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_PAYLOAD,
        PH_CHK_A,
        PH_CHK_B
    } t_phase;

    // one result item
    typedef struct packed {
        t_kind                    kind;
        logic [BYTE_INDEX_W-1:0]  byte_index;
        logic [7:0]               data_byte;
        logic [7:0]               msg_class;
        logic [7:0]               msg_id;
        logic [LENGTH_W-1:0]      payload_length;
        logic                     checksum_ok;
        logic                     truncated;
    } t_result;

endpackage

// ===== design/fpr_parser.sv =====
// ----------------------------------------------------------------------------
// fpr_parser - frame parser and Fletcher checksum
// Walks through sync, header, payload and checksum bytes one item per cycle
// when accepted, keeps running sums and forms at most one result per byte.
// ----------------------------------------------------------------------------
module fpr_parser #(
    parameter int unsigned PAYLOAD_STORE_BYTES = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [fpr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                    i_cfg_data,
    input  logic                          i_accept,
    input  logic [7:0]                    i_byte,
    output logic                          o_res_valid,
    output fpr_pkg::t_result              o_res
);
    import fpr_pkg::*;

    localparam logic [LENGTH_W-1:0] STORE_LIMIT = LENGTH_W'(PAYLOAD_STORE_BYTES);

    logic [7:0]          r_sync_first, r_sync_second;
    t_phase              r_phase, n_phase;
    logic [LENGTH_W-1:0] r_length, n_length;
    logic [LENGTH_W-1:0] r_payload_pos, n_payload_pos;
    logic [7:0]          r_sum_a, n_sum_a;
    logic [7:0]          r_sum_b, n_sum_b;
    logic [7:0]          r_class, n_class;
    logic [7:0]          r_id, n_id;
    logic [7:0]          r_check_a, n_check_a;

    logic [7:0]          w_add_a, w_add_b;
    logic [LENGTH_W-1:0] w_len_full, w_pos_inc;
    logic                w_in_store, w_truncated;

    // running sums and header helpers
    assign w_add_a     = r_sum_a + i_byte;
    assign w_add_b     = r_sum_b + w_add_a;
    assign w_len_full  = {i_byte, r_length[7:0]};
    assign w_pos_inc   = r_payload_pos + 1'b1;
    assign w_in_store  = (r_payload_pos < STORE_LIMIT);
    assign w_truncated = (r_length > STORE_LIMIT);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first  <= SYNC_FIRST_RST;
            r_sync_second <= SYNC_SECOND_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SYNC_FIRST:  r_sync_first  <= i_cfg_data;
                CFG_SYNC_SECOND: r_sync_second <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (i_accept) begin
            case (r_phase)
                PH_HUNT:    if (i_byte == r_sync_first) n_phase = PH_SYNC2;
                PH_SYNC2:   n_phase = (i_byte == r_sync_second) ? PH_CLASS : PH_HUNT;
                PH_CLASS:   n_phase = PH_ID;
                PH_ID:      n_phase = PH_LEN_LO;
                PH_LEN_LO:  n_phase = PH_LEN_HI;
                PH_LEN_HI:  n_phase = (w_len_full == '0) ? PH_CHK_A : PH_PAYLOAD;
                PH_PAYLOAD: if (w_pos_inc == r_length) n_phase = PH_CHK_A;
                PH_CHK_A:   n_phase = PH_CHK_B;
                PH_CHK_B:   n_phase = PH_HUNT;
                default:    n_phase = PH_HUNT;
            endcase
        end
    end

    // datapath updates and result forming
    always_comb begin
        n_length      = r_length;
        n_payload_pos = r_payload_pos;
        n_sum_a       = r_sum_a;
        n_sum_b       = r_sum_b;
        n_class       = r_class;
        n_id          = r_id;
        n_check_a     = r_check_a;
        o_res_valid   = 1'b0;
        o_res.kind           = KIND_PAYLOAD;
        o_res.byte_index     = r_payload_pos[BYTE_INDEX_W-1:0];
        o_res.data_byte      = i_byte;
        o_res.msg_class      = r_class;
        o_res.msg_id         = r_id;
        o_res.payload_length = r_length;
        o_res.checksum_ok    = 1'b0;
        o_res.truncated      = w_truncated;
        if (i_accept) begin
            case (r_phase)
                PH_SYNC2: begin
                    n_sum_a = '0;
                    n_sum_b = '0;
                end
                PH_CLASS: begin
                    n_class = i_byte;
                    n_sum_a = w_add_a;
                    n_sum_b = w_add_b;
                end
                PH_ID: begin
                    n_id    = i_byte;
                    n_sum_a = w_add_a;
                    n_sum_b = w_add_b;
                end
                PH_LEN_LO: begin
                    n_length = {8'd0, i_byte};
                    n_sum_a  = w_add_a;
                    n_sum_b  = w_add_b;
                end
                PH_LEN_HI: begin
                    n_length      = w_len_full;
                    n_payload_pos = '0;
                    n_sum_a       = w_add_a;
                    n_sum_b       = w_add_b;
                end
                PH_PAYLOAD: begin
                    o_res_valid   = w_in_store;
                    n_payload_pos = w_pos_inc;
                    n_sum_a       = w_add_a;
                    n_sum_b       = w_add_b;
                end
                PH_CHK_A: n_check_a = i_byte;
                PH_CHK_B: begin
                    o_res_valid       = 1'b1;
                    o_res.kind        = KIND_FRAME_END;
                    o_res.byte_index  = '0;
                    o_res.data_byte   = '0;
                    o_res.checksum_ok = (r_check_a == r_sum_a) && (i_byte == r_sum_b);
                end
                default: ;
            endcase
        end
    end

    // phase register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
        end else begin
            r_phase <= n_phase;
        end
    end

    // frame state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length      <= '0;
            r_payload_pos <= '0;
            r_sum_a       <= '0;
            r_sum_b       <= '0;
            r_class       <= '0;
            r_id          <= '0;
            r_check_a     <= '0;
        end else begin
            r_length      <= n_length;
            r_payload_pos <= n_payload_pos;
            r_sum_a       <= n_sum_a;
            r_sum_b       <= n_sum_b;
            r_class       <= n_class;
            r_id          <= n_id;
            r_check_a     <= n_check_a;
        end
    end

    // a frame end always returns the parser to hunting
    a_end_to_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.kind == KIND_FRAME_END) |=> (r_phase == PH_HUNT))
        else $error("parser did not return to hunting after frame end");

    // payload results stay inside the declared length
    a_payload_in_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.kind == KIND_PAYLOAD) |-> (r_payload_pos < r_length))
        else $error("payload result beyond declared length");

    // the payload phase is never entered with a zero length
    a_payload_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_length != '0))
        else $error("payload phase with zero length");

endmodule

// ===== design/fpr_out_buf.sv =====
// ----------------------------------------------------------------------------
// fpr_out_buf - two-entry result buffer
// Output register plus a skid entry, so the parser keeps taking bytes
// until a second result waits behind a stalled output register.
// ----------------------------------------------------------------------------
module fpr_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  fpr_pkg::t_result i_res,
    output logic             o_ready,
    output logic             o_valid,
    input  logic             i_ready,
    output fpr_pkg::t_result o_res
);
    import fpr_pkg::*;

    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid, n_skid;
    logic    w_take;

    assign w_take  = r_out_valid && i_ready;
    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    // buffer steering
    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (r_skid_valid) begin
            if (w_take) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (i_valid) begin
            if (!r_out_valid || w_take) begin
                n_out       = i_res;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = i_res;
                n_skid_valid = 1'b1;
            end
        end else if (w_take) begin
            n_out_valid = 1'b0;
        end
    end

    // control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    // the skid entry is only used behind a full output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with empty output register");

    // a full skid entry holds while the output is stalled
    a_no_write_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_ready) |=> r_skid_valid && $stable(r_skid))
        else $error("skid entry changed while stalled");

endmodule

// ===== design/framed_packet_receiver_fletcher8.sv =====
// ----------------------------------------------------------------------------
// framed_packet_receiver_fletcher8 - framed packet receiver, Fletcher-8 check
// Parses sync, class, id, length, payload and checksum bytes from a byte
// stream and reports payload bytes and a per-frame status.
// ----------------------------------------------------------------------------
// Usage
//   Bytes enter on the s_axis channel, one item per byte. Result items leave
//   on m_axis: tuser 0 is a payload byte with its index, tuser 1 is the
//   frame-end status (class, id, length, checksum match, truncation).
//   Payload bytes at or beyond PAYLOAD_STORE_BYTES enter the checksum but
//   give no result item.
//   Sync byte values are written on the cfg channel (index 0 first sync,
//   index 1 second sync) while no frame is in flight; cfg is always ready.
//   A taken byte's result is registered in the output register, or in the
//   skid entry while the output is stalled. Throughput: one byte per cycle
//   while o_s_axis_tready is high; the parser step is a compare, a counter
//   increment and two 8-bit adds between frame state and result register.
//   Reset: sync values return to 0xB5 / 0x62 and the parser hunts for a
//   first sync byte; the output buffer is emptied.
//   Stall: the output holds a result register and one skid entry;
//   o_s_axis_tready drops once both are full and rises when m_axis drains.
// ----------------------------------------------------------------------------
module framed_packet_receiver_fletcher8 #(
    parameter int unsigned PAYLOAD_STORE_BYTES = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [fpr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [7:0]                      i_cfg_data,
    // byte input
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [7:0]                      i_s_axis_tdata,   // [7:0] in_byte
    // result output
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // [9:0] byte_index, [17:10] data_byte, [25:18] msg_class, [33:26] msg_id,
    // [49:34] payload_length, [50] checksum_ok, [51] truncated, [55:52] zero
    output logic [fpr_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    output logic [0:0]                      o_m_axis_tuser    // [0] result_kind
);
    import fpr_pkg::*;

    logic    w_accept;
    logic    w_res_valid;
    t_result w_res;
    t_result w_out;

    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_s_axis_tvalid && o_s_axis_tready;

    // frame parser
    fpr_parser #(
        .PAYLOAD_STORE_BYTES (PAYLOAD_STORE_BYTES)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (w_accept),
        .i_byte      (i_s_axis_tdata),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // result buffer
    fpr_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_res_valid),
        .i_res   (w_res),
        .o_ready (o_s_axis_tready),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_res   (w_out)
    );

    // pack result fields
    assign o_m_axis_tuser = 1'(w_out.kind);
    assign o_m_axis_tdata = {4'd0, w_out.truncated, w_out.checksum_ok,
                             w_out.payload_length, w_out.msg_id, w_out.msg_class,
                             w_out.data_byte, w_out.byte_index};

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the framed packet receiver
// Drives byte streams into the receiver: a short table of hand-made frames,
// then random frames, broken frames and noise under four sync settings and
// four idle/stall mixes. A bench frame parser predicts payload and frame-end
// items of untyped rows. Results are compared field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;
    import fpr_pkg::*;

    localparam int unsigned STORE_BYTES  = 1024;
    localparam logic [16:0] HDR_BYTES    = 17'd6;
    localparam logic [16:0] CHK_B_OFFSET = 17'd7;
    localparam int RANDOM_ITEMS   = 75;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MAX_REPORTS    = 100;
    localparam int NUM_PHASES     = 4;

    // register indexes that map to nothing
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 2'd3;

    typedef enum int {
        FLAW_NONE,
        FLAW_CHECKSUM,
        FLAW_CUT
    } t_flaw;

    typedef struct {
        logic [7:0] in_byte;
        bit         typed;
        bit         has_res;
        t_result    res;
    } t_row;

    localparam t_result NO_RESULT = '0;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [7:0]             i_cfg_data;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    logic [7:0]             i_s_axis_tdata;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic [0:0]             o_m_axis_tuser;

    // sync values and frame parser state as the bench sees them
    logic [7:0]  sync_first_val  = SYNC_FIRST_RST;
    logic [7:0]  sync_second_val = SYNC_SECOND_RST;
    logic        rx_in_frame = 1'b0;
    logic [16:0] rx_pos      = '0;
    logic [15:0] rx_len      = '0;
    logic [15:0] rx_pay_pos  = '0;
    logic [7:0]  rx_sum_a    = '0;
    logic [7:0]  rx_sum_b    = '0;
    logic [7:0]  rx_class    = '0;
    logic [7:0]  rx_id       = '0;
    logic [7:0]  rx_chk_a    = '0;

    t_result expected_results [$];
    int      error_count   = 0;
    int      bytes_taken   = 0;
    int      quiet_cycles  = 0;
    int      src_idle_pct  = 0;
    int      sink_stall_pct = 0;

    int src_idle_by_phase   [NUM_PHASES] = '{0, 66, 0, 36};
    int sink_stall_by_phase [NUM_PHASES] = '{0, 0, 66, 36};

    // hand-made frames; typed rows carry their own expected item
    t_row directed_rows [23] = '{
        // noise ahead of any frame
        '{8'h62, 1'b1, 1'b0, NO_RESULT},
        // a repeated first sync byte abandons the frame
        '{8'hB5, 1'b0, 1'b0, NO_RESULT},
        '{8'hB5, 1'b1, 1'b0, NO_RESULT},
        // the abandoning byte is not taken as a new first sync
        '{8'h62, 1'b1, 1'b0, NO_RESULT},
        // class ff, id 00, two payload bytes equal to the sync values
        '{8'hB5, 1'b0, 1'b0, NO_RESULT},
        '{8'h62, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h02, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'hB5, 1'b1, 1'b1,
            '{KIND_PAYLOAD, 10'd0, 8'hB5, 8'hFF, 8'h00, 16'd2, 1'b0, 1'b0}},
        '{8'h62, 1'b1, 1'b1,
            '{KIND_PAYLOAD, 10'd1, 8'h62, 8'hFF, 8'h00, 16'd2, 1'b0, 1'b0}},
        '{8'h18, 1'b0, 1'b0, NO_RESULT},
        '{8'hCE, 1'b1, 1'b1,
            '{KIND_FRAME_END, 10'd0, 8'h00, 8'hFF, 8'h00, 16'd2, 1'b1, 1'b0}},
        // zero length frame with a wrong checksum a
        '{8'hB5, 1'b0, 1'b0, NO_RESULT},
        '{8'h62, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'hFD, 1'b1, 1'b1,
            '{KIND_FRAME_END, 10'd0, 8'h00, 8'h00, 8'hFF, 16'd0, 1'b0, 1'b0}},
        '{8'hFF, 1'b0, 1'b0, NO_RESULT}
    };

    framed_packet_receiver_fletcher8 #(
        .PAYLOAD_STORE_BYTES(STORE_BYTES)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // frame parser: advances on one byte, returns 1 when an item is due
    function automatic bit parse_byte(input logic [7:0] b, output t_result res);
        logic [16:0] len_ext;
        bit          produced;
        res = '0;
        if (!rx_in_frame) begin
            if (b == sync_first_val) begin
                rx_in_frame = 1'b1;
                rx_pos      = 17'(PH_SYNC2);
            end
            return 1'b0;
        end
        if (rx_pos == 17'(PH_SYNC2)) begin
            if (b == sync_second_val) begin
                rx_pos   = 17'(PH_CLASS);
                rx_sum_a = '0;
                rx_sum_b = '0;
            end else begin
                rx_in_frame = 1'b0;
            end
            return 1'b0;
        end
        if (rx_pos < HDR_BYTES) begin
            case (t_phase'(rx_pos[3:0]))
                PH_CLASS:  rx_class = b;
                PH_ID:     rx_id    = b;
                PH_LEN_LO: rx_len   = {8'h00, b};
                default: begin
                    rx_len[15:8] = b;
                    rx_pay_pos   = '0;
                end
            endcase
            rx_pos   = rx_pos + 17'd1;
            rx_sum_a = rx_sum_a + b;
            rx_sum_b = rx_sum_b + rx_sum_a;
            return 1'b0;
        end
        // fields shared by both item kinds
        res.msg_class      = rx_class;
        res.msg_id         = rx_id;
        res.payload_length = rx_len;
        res.truncated      = (rx_len > STORE_BYTES);
        len_ext            = {1'b0, rx_len};
        if (rx_pay_pos < rx_len) begin
            produced = (rx_pay_pos < STORE_BYTES);
            res.kind       = KIND_PAYLOAD;
            res.byte_index = rx_pay_pos[BYTE_INDEX_W-1:0];
            res.data_byte  = b;
            rx_pay_pos = rx_pay_pos + 16'd1;
            rx_pos     = rx_pos + 17'd1;
            rx_sum_a   = rx_sum_a + b;
            rx_sum_b   = rx_sum_b + rx_sum_a;
            return produced;
        end
        if (rx_pos == len_ext + HDR_BYTES) begin
            rx_chk_a = b;
            rx_pos   = rx_pos + 17'd1;
            return 1'b0;
        end
        if (rx_pos == len_ext + CHK_B_OFFSET) begin
            res.kind        = KIND_FRAME_END;
            res.checksum_ok = (rx_chk_a == rx_sum_a) && (b == rx_sum_b);
            rx_pos      = rx_pos + 17'd1;
            rx_in_frame = 1'b0;
            return 1'b1;
        end
        rx_in_frame = 1'b0;
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("mismatch: %s", what);
    endtask

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want)
            report_mismatch($sformatf("%s expected %0h got %0h", name, want, got));
    endtask

    // send one byte; typed rows override the parser's prediction
    task automatic push_byte(input logic [7:0] b, input bit typed = 1'b0,
                             input bit has_res = 1'b0,
                             input t_result typed_res = '0);
        t_result pred;
        bit      produced;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        do @(posedge i_clk); while (!o_s_axis_tready);
        bytes_taken++;
        produced = parse_byte(b, pred);
        if (typed) begin
            if (has_res)
                expected_results.push_back(typed_res);
        end else if (produced) begin
            expected_results.push_back(pred);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_SYNC_FIRST:  sync_first_val  = val;
            CFG_SYNC_SECOND: sync_second_val = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // stop sending and let every pending item come out
    task automatic quiesce();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [7:0] wrong_second();
        return sync_second_val + 8'($urandom_range(1, 255));
    endfunction

    // payload content leans toward sync values and the byte extremes
    function automatic logic [7:0] pick_payload();
        case ($urandom_range(0, 15))
            0:       return sync_first_val;
            1:       return sync_second_val;
            2:       return 8'h00;
            3:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 16'd0;
        return 16'($urandom_range(1, 24));
    endfunction

    task automatic add_and_push(inout logic [7:0] ca, inout logic [7:0] cb,
                                input logic [7:0] b);
        ca = ca + b;
        cb = cb + ca;
        push_byte(b);
    endtask

    // random bytes until the current frame closes
    task automatic drain_frame();
        while (rx_in_frame)
            push_byte((rx_pos == 17'(PH_SYNC2)) ? wrong_second() : 8'($urandom));
    endtask

    task automatic send_frame(input logic [15:0] len, input t_flaw flaw);
        logic [7:0] ca;
        logic [7:0] cb;
        int         cut_at;
        ca = '0;
        cb = '0;
        push_byte(sync_first_val);
        push_byte(sync_second_val);
        add_and_push(ca, cb, 8'($urandom));
        add_and_push(ca, cb, 8'($urandom));
        add_and_push(ca, cb, len[7:0]);
        add_and_push(ca, cb, len[15:8]);
        cut_at = (flaw == FLAW_CUT) ? $urandom_range(0, len) : int'(len);
        for (int i = 0; i < cut_at; i++)
            add_and_push(ca, cb, pick_payload());
        if (flaw == FLAW_CUT) begin
            // a new frame starts early and is swallowed as data
            push_byte(sync_first_val);
            push_byte(sync_second_val);
            drain_frame();
        end else begin
            if (flaw == FLAW_CHECKSUM) begin
                if ($urandom_range(0, 1) == 0)
                    ca = ca ^ 8'($urandom_range(1, 255));
                else
                    cb = cb ^ 8'($urandom_range(1, 255));
            end
            push_byte(ca);
            push_byte(cb);
        end
    endtask

    task automatic random_segment();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            send_frame(pick_length(), FLAW_NONE);
        end else if (r < 75) begin
            send_frame(pick_length(), FLAW_CHECKSUM);
        end else if (r < 83) begin
            send_frame(pick_length(), FLAW_CUT);
        end else if (r < 90) begin
            push_byte(sync_first_val);
            push_byte(wrong_second());
        end else begin
            // noise, often hitting the first sync value
            n = $urandom_range(1, 8);
            repeat (n) begin
                if (rx_in_frame)
                    push_byte(wrong_second());
                else
                    push_byte(($urandom_range(0, 3) == 0) ? sync_first_val
                                                          : 8'($urandom));
            end
            drain_frame();
        end
    endtask

    // receiver stalls
    always @(negedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // result check
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.kind           = t_kind'(o_m_axis_tuser[0]);
            got.byte_index     = o_m_axis_tdata[9:0];
            got.data_byte      = o_m_axis_tdata[17:10];
            got.msg_class      = o_m_axis_tdata[25:18];
            got.msg_id         = o_m_axis_tdata[33:26];
            got.payload_length = o_m_axis_tdata[49:34];
            got.checksum_ok    = o_m_axis_tdata[50];
            got.truncated      = o_m_axis_tdata[51];
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("item with none expected, kind %0d", got.kind));
            end else begin
                want = expected_results.pop_front();
                compare_field("result_kind", 16'(want.kind), 16'(got.kind));
                compare_field("byte_index", 16'(want.byte_index), 16'(got.byte_index));
                compare_field("data_byte", 16'(want.data_byte), 16'(got.data_byte));
                compare_field("msg_class", 16'(want.msg_class), 16'(got.msg_class));
                compare_field("msg_id", 16'(want.msg_id), 16'(got.msg_id));
                compare_field("payload_length", want.payload_length, got.payload_length);
                compare_field("checksum_ok", 16'(want.checksum_ok), 16'(got.checksum_ok));
                compare_field("truncated", 16'(want.truncated), 16'(got.truncated));
            end
        end
    end

    // watchdog on cycles with no handshake anywhere
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // main sequence
    initial begin
        int start;
        logic [7:0] v;
        i_rst_n         = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = CFG_SYNC_FIRST;
        i_cfg_data      = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_m_axis_tready = 1'b1;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // hand-made frames under the reset sync values
        for (int i = 0; i < $size(directed_rows); i++)
            push_byte(directed_rows[i].in_byte, directed_rows[i].typed,
                      directed_rows[i].has_res, directed_rows[i].res);

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p != 0) begin
                quiesce();
                case (p)
                    1: begin
                        write_reg(CFG_SYNC_FIRST, 8'h00);
                        write_reg(CFG_SYNC_SECOND, 8'hFF);
                    end
                    2: begin
                        write_reg(CFG_SYNC_FIRST, 8'hFF);
                        write_reg(CFG_SYNC_SECOND, 8'h00);
                    end
                    default: begin
                        // both sync values equal; spare indexes must be ignored
                        v = 8'($urandom);
                        write_reg(CFG_SYNC_FIRST, v);
                        write_reg(CFG_SYNC_SECOND, v);
                        write_reg(CFG_IDX_SPARE_LO, 8'($urandom));
                        write_reg(CFG_IDX_SPARE_HI, 8'($urandom));
                    end
                endcase
            end
            src_idle_pct   = src_idle_by_phase[p];
            sink_stall_pct = sink_stall_by_phase[p];
            // one frame just past the payload store size
            if (p == 0)
                send_frame(16'(STORE_BYTES + 1), FLAW_NONE);
            start = bytes_taken;
            while (bytes_taken - start < RANDOM_ITEMS)
                random_segment();
        end

        quiesce();
        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d items never arrived", expected_results.size()));
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== sim.f =====
design/fpr_pkg.sv
design/fpr_parser.sv
design/fpr_out_buf.sv
design/framed_packet_receiver_fletcher8.sv
dv/tb_top.sv
